// ===== rtl/prj_pkg.sv =====
// ---------------------------------------------------------------------------
// prj_pkg
// shared types, constants and helpers for the point rotate and project block
// ---------------------------------------------------------------------------
package prj_pkg;

  localparam int unsigned FRAME_WIDTH_DEF  = 640;
  localparam int unsigned FRAME_HEIGHT_DEF = 640;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned DELTA_W = 48;
  localparam int unsigned TRIG_W  = 16;
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned NUM_W   = 63;
  localparam int unsigned DEN_W   = 52;
  localparam int unsigned QUO_W   = 17;
  localparam int unsigned DIV_LAT = QUO_W + 1;

  localparam logic [23:0]        SCALE_RESET = 24'd52429;
  localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
  localparam logic signed [25:0] HALF_Q16    = 26'sd32768;
  localparam logic signed [48:0] EYE_OFS     = 49'sd131072;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_SHIFT_X   = 3'd1,
    REG_SHIFT_Y   = 3'd2,
    REG_SHIFT_Z   = 3'd3,
    REG_SCALE     = 3'd4,
    REG_ROT_ZX    = 3'd5,
    REG_ROT_Y     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic vld;
    logic fe;
  } ctl_t;

  typedef struct packed {
    logic [PIX_W-1:0] px2;
    logic [PIX_W-1:0] py2;
    logic             behind;
    logic             sx;
    logic             sy;
  } side_t;

  function automatic logic [PIX_W-1:0] sat16(input logic signed [63:0] v);
    logic [PIX_W-1:0] r;
    if (v > 64'sd32767) begin
      r = 16'h7fff;
    end else if (v < -64'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/prj_prep.sv =====
// ---------------------------------------------------------------------------
// prj_prep
// shift, optional wrap to unit box and rescale about one half, two stages
// ---------------------------------------------------------------------------
module prj_prep import prj_pkg::*; (
  input  logic                      clk_i,
  input  logic                      adv_i,
  input  logic signed [POS_W-1:0]   pos_i,
  input  logic signed [POS_W-1:0]   shift_i,
  input  logic [23:0]               scale_i,
  input  logic                      wrap_i,
  output logic signed [DELTA_W-1:0] delta_o
);

  logic signed [24:0] sum;
  logic signed [25:0] d_d, d_q;
  logic signed [50:0] prod_d, prod_q;

  always_comb begin
    sum = 25'(pos_i) + 25'(shift_i);
    if (wrap_i) begin
      d_d = $signed({10'b0, sum[15:0]}) - HALF_Q16;
    end else begin
      d_d = 26'(sum) - HALF_Q16;
    end
    prod_d = 51'(d_q) * 51'($signed({1'b0, scale_i}));
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d_q    <= d_d;
      prod_q <= prod_d;
    end
  end

  assign delta_o = DELTA_W'(prod_q >>> 16);

endmodule

// ===== rtl/prj_rot.sv =====
// ---------------------------------------------------------------------------
// prj_rot
// plane rotation of two offsets from the center, products then sums
// ---------------------------------------------------------------------------
module prj_rot import prj_pkg::*; (
  input  logic                      clk_i,
  input  logic                      adv_i,
  input  logic signed [DELTA_W-1:0] a_i,
  input  logic signed [DELTA_W-1:0] b_i,
  input  logic signed [DELTA_W-1:0] t_i,
  input  logic signed [TRIG_W-1:0]  c_i,
  input  logic signed [TRIG_W-1:0]  s_i,
  output logic signed [DELTA_W-1:0] a_o,
  output logic signed [DELTA_W-1:0] b_o,
  output logic signed [DELTA_W-1:0] t_o
);

  logic signed [63:0] ca_q, sb_q, sa_q, cb_q;
  logic signed [DELTA_W-1:0] t1_q, a_q, b_q, t2_q;
  logic signed [64:0] sum_a, sum_b;

  always_comb begin
    sum_a = 65'(ca_q) - 65'(sb_q);
    sum_b = 65'(sa_q) + 65'(cb_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ca_q <= 64'(c_i) * 64'(a_i);
      sb_q <= 64'(s_i) * 64'(b_i);
      sa_q <= 64'(s_i) * 64'(a_i);
      cb_q <= 64'(c_i) * 64'(b_i);
      t1_q <= t_i;
      a_q  <= DELTA_W'(sum_a >>> 14);
      b_q  <= DELTA_W'(sum_b >>> 14);
      t2_q <= t1_q;
    end
  end

  assign a_o = a_q;
  assign b_o = b_q;
  assign t_o = t2_q;

endmodule

// ===== rtl/prj_div.sv =====
// ---------------------------------------------------------------------------
// prj_div
// pipelined restoring divider, one quotient bit per stage, overflow flag
// ---------------------------------------------------------------------------
module prj_div import prj_pkg::*; (
  input  logic              clk_i,
  input  logic              adv_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic [QUO_W-1:0]  quo_o,
  output logic              ovf_o
);

  localparam int unsigned CW = NUM_W + QUO_W;

  logic [NUM_W-1:0] rem_q [QUO_W+1];
  logic [DEN_W-1:0] den_q [QUO_W+1];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic             ovf_q [QUO_W+1];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= CW'(num_i) >= (CW'(den_i) << QUO_W);
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    localparam int unsigned BIT = QUO_W - 1 - k;
    logic [CW-1:0] dsh;
    logic          ge;
    assign dsh = CW'(den_q[k]) << BIT;
    assign ge  = CW'(rem_q[k]) >= dsh;
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k+1] <= ge ? NUM_W'(CW'(rem_q[k]) - dsh) : rem_q[k];
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= quo_q[k] | (QUO_W'(ge) << BIT);
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign quo_o = quo_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];

endmodule

// ===== rtl/point_rotate_project.sv =====
// ---------------------------------------------------------------------------
// point_rotate_project
// particle position to screen pixel, 2d or rotated 3d perspective view
// ---------------------------------------------------------------------------
// input beats carry one particle position (x, y, z, signed Q8.16) on
// s_axis_tdata with the frame end marker on s_axis_tlast. each beat gives
// one output beat with the pixel column and row on m_axis_tdata, the
// visible flag on m_axis_tuser and the frame end marker on m_axis_tlast.
// registers are written on the cfg channel, always ready; the user must write them
// only while no beat is in flight, the block itself does not enforce it.
// one beat per cycle is taken and given while m_axis_tready does not stall.
// the depth is the rescale stages, three two-stage rotations, the projection
// setup, the 18 stage divider of the perspective step and the output register.
// a stall on m_axis_tready freezes every stage and drops s_axis_tready in
// the same cycle; nothing is lost or repeated.
// reset clears all valid bits and sets registers to their defaults: 2d,
// no wrap, no shift, scale 52429, all trig values zero.
// ---------------------------------------------------------------------------
module point_rotate_project import prj_pkg::*; #(
  parameter int unsigned FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // pos_x, pos_y, pos_z
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // pixel_x, pixel_y
  output logic        m_axis_tuser,   // visible
  output logic        m_axis_tlast
);

  localparam int unsigned NSTG = 2 + 3 * 2 + 3 + DIV_LAT + 1;
  localparam logic signed [13:0] FW = 14'(FRAME_WIDTH);
  localparam logic signed [13:0] FH = 14'(FRAME_HEIGHT);

  logic [1:0]        mode_q;
  logic [23:0]       shx_q, shy_q, shz_q, scale_q;
  logic [63:0]       rzx_q;
  logic [31:0]       ry_q;
  logic              adv;
  ctl_t              ctl_q [NSTG];

  logic signed [DELTA_W-1:0] px0, py0, pz0;
  logic signed [DELTA_W-1:0] x1, y1, z1, y2, z2, x2, z3, x3, y3;
  logic signed [TRIG_W-1:0]  cz, sz, cx, sx, cy, sy;
  logic                      three;

  logic signed [48:0] zd;
  logic signed [53:0] tx_q, ty_q;
  logic signed [48:0] xs_q, ys_q;
  logic [DEN_W-1:0]   den_q, den_p2_q, den_p3_q;
  logic               behind_q, behind_p2_q;
  logic signed [63:0] numx_q, numy_q, x2d_q, y2d_q, x2t, y2t;
  logic [NUM_W-1:0]   absx_q, absy_q;
  side_t              side_q [DIV_LAT+1];
  side_t              side_d;
  logic [QUO_W-1:0]   qx, qy;
  logic               ovx, ovy;
  logic [PIX_W-1:0]   pxo_q, pyo_q;
  logic               viso_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      shx_q   <= '0;
      shy_q   <= '0;
      shz_q   <= '0;
      scale_q <= SCALE_RESET;
      rzx_q   <= '0;
      ry_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_MODE:    mode_q  <= cfg_data_i[1:0];
        REG_SHIFT_X: shx_q   <= cfg_data_i[23:0];
        REG_SHIFT_Y: shy_q   <= cfg_data_i[23:0];
        REG_SHIFT_Z: shz_q   <= cfg_data_i[23:0];
        REG_SCALE:   scale_q <= cfg_data_i[23:0];
        REG_ROT_ZX:  rzx_q   <= cfg_data_i;
        REG_ROT_Y:   ry_q    <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  assign adv           = !ctl_q[NSTG-1].vld || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTG; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (adv) begin
      ctl_q[0] <= '{vld: s_axis_tvalid, fe: s_axis_tlast};
      for (int i = 1; i < NSTG; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  // rescale
  prj_prep u_prep_x (
    .clk_i, .adv_i(adv), .pos_i(s_axis_tdata[23:0]), .shift_i(shx_q),
    .scale_i(scale_q), .wrap_i(mode_q[0]), .delta_o(px0)
  );
  prj_prep u_prep_y (
    .clk_i, .adv_i(adv), .pos_i(s_axis_tdata[47:24]), .shift_i(shy_q),
    .scale_i(scale_q), .wrap_i(mode_q[0]), .delta_o(py0)
  );
  prj_prep u_prep_z (
    .clk_i, .adv_i(adv), .pos_i(s_axis_tdata[71:48]), .shift_i(shz_q),
    .scale_i(scale_q), .wrap_i(mode_q[0]), .delta_o(pz0)
  );

  // rotations, identity in 2d mode
  assign three = mode_q[1];
  assign cz = three ? rzx_q[15:0]  : ONE_Q14;
  assign sz = three ? rzx_q[31:16] : '0;
  assign cx = three ? rzx_q[47:32] : ONE_Q14;
  assign sx = three ? rzx_q[63:48] : '0;
  assign cy = three ? ry_q[15:0]   : ONE_Q14;
  assign sy = three ? ry_q[31:16]  : '0;

  prj_rot u_rot_xy (
    .clk_i, .adv_i(adv), .a_i(px0), .b_i(py0), .t_i(pz0), .c_i(cz), .s_i(sz),
    .a_o(x1), .b_o(y1), .t_o(z1)
  );
  prj_rot u_rot_yz (
    .clk_i, .adv_i(adv), .a_i(y1), .b_i(z1), .t_i(x1), .c_i(cx), .s_i(sx),
    .a_o(y2), .b_o(z2), .t_o(x2)
  );
  prj_rot u_rot_zx (
    .clk_i, .adv_i(adv), .a_i(z2), .b_i(x2), .t_i(y2), .c_i(cy), .s_i(sy),
    .a_o(z3), .b_o(x3), .t_o(y3)
  );

  // projection setup
  assign zd = 49'(z3) + EYE_OFS;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tx_q        <= 54'(x3) * 54'sd12 + 54'(zd) * 54'sd5;
      ty_q        <= 54'(y3) * 54'sd12 + 54'(zd) * 54'sd5;
      den_q       <= DEN_W'(53'(zd) * 53'sd10);
      behind_q    <= zd[48] || (zd == '0);
      xs_q        <= 49'(x3) + 49'sd32768;
      ys_q        <= 49'(y3) + 49'sd32768;
      numx_q      <= 64'(tx_q) * 64'(FW);
      numy_q      <= 64'(ty_q) * 64'(FH);
      x2d_q       <= 64'(xs_q) * 64'(FW);
      y2d_q       <= 64'(ys_q) * 64'(FH);
      den_p2_q    <= den_q;
      behind_p2_q <= behind_q;
      absx_q      <= NUM_W'(numx_q[63] ? -numx_q : numx_q);
      absy_q      <= NUM_W'(numy_q[63] ? -numy_q : numy_q);
      den_p3_q    <= den_p2_q;
    end
  end

  assign x2t = (x2d_q + (x2d_q[63] ? 64'sd65535 : 64'sd0)) >>> 16;
  assign y2t = (y2d_q + (y2d_q[63] ? 64'sd65535 : 64'sd0)) >>> 16;

  assign side_d = '{px2: sat16(x2t), py2: sat16(y2t), behind: behind_p2_q,
                    sx: numx_q[63], sy: numy_q[63]};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_d;
      for (int i = 1; i < DIV_LAT + 1; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // perspective divide
  prj_div u_div_x (
    .clk_i, .adv_i(adv), .num_i(absx_q), .den_i(den_p3_q), .quo_o(qx), .ovf_o(ovx)
  );
  prj_div u_div_y (
    .clk_i, .adv_i(adv), .num_i(absy_q), .den_i(den_p3_q), .quo_o(qy), .ovf_o(ovy)
  );

  function automatic logic [PIX_W-1:0] signed_sat(input logic [QUO_W-1:0] q,
                                                  input logic ovf, input logic neg);
    logic [PIX_W-1:0] r;
    if (!neg) begin
      r = (ovf || q > QUO_W'(32767)) ? 16'h7fff : q[PIX_W-1:0];
    end else begin
      r = (ovf || q > QUO_W'(32768)) ? 16'h8000 : PIX_W'(-q);
    end
    return r;
  endfunction

  // output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (!three) begin
        pxo_q  <= side_q[DIV_LAT].px2;
        pyo_q  <= side_q[DIV_LAT].py2;
        viso_q <= 1'b1;
      end else if (side_q[DIV_LAT].behind) begin
        pxo_q  <= '1;
        pyo_q  <= '1;
        viso_q <= 1'b0;
      end else begin
        pxo_q  <= signed_sat(qx, ovx, side_q[DIV_LAT].sx);
        pyo_q  <= signed_sat(qy, ovy, side_q[DIV_LAT].sy);
        viso_q <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = ctl_q[NSTG-1].vld;
  assign m_axis_tlast  = ctl_q[NSTG-1].fe;
  assign m_axis_tdata  = {pyo_q, pxo_q};
  assign m_axis_tuser  = viso_q;

`ifndef NO_ASSERTIONS
  a_hidden_pix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'hffff_ffff)
    else $error("hidden point without -1 pixels");

  a_flat_vis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !mode_q[1] |-> m_axis_tuser)
    else $error("2d point not visible");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(ctl_q[NSTG-1]) && $stable(ctl_q[0]))
    else $error("pipeline moved during stall");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ctl_q[0].vld)
    else $error("accepted beat not tracked");
`endif

endmodule
